// ===== rtl/gbts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants of the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  // Field widths of the request and response channels
  localparam int REQ_W    = 2;
  localparam int POS_W    = 11;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // Default store size in bytes
  localparam int CAPACITY_DEF = 1024;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_RANGE  = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2,
    STS_RSVD = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/gbts_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_req_if
// Request channel: edit or read command with position and byte.
// ----------------------------------------------------------------------------
interface gbts_req_if;
  logic                       valid;
  logic                       ready;
  logic [gbts_pkg::REQ_W-1:0] req_type;
  logic [gbts_pkg::POS_W-1:0] position;
  logic [gbts_pkg::POS_W-1:0] end_position;
  logic [gbts_pkg::BYTE_W-1:0] char_value;

  modport source (output valid, req_type, position, end_position, char_value,
                  input ready);
  modport sink   (input valid, req_type, position, end_position, char_value,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/gbts_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_rsp_if
// Response channel: byte read, text length and status.
// ----------------------------------------------------------------------------
interface gbts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gbts_pkg::BYTE_W-1:0]   read_byte;
  logic [gbts_pkg::POS_W-1:0]    text_length;
  logic [gbts_pkg::STATUS_W-1:0] status;

  modport source (output valid, read_byte, text_length, status, input ready);
  modport sink   (input valid, read_byte, text_length, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/gbts_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_mem
// Character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbts_mem #(
  parameter int DEPTH = gbts_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [gbts_pkg::BYTE_W-1:0]   wdata,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output logic      [gbts_pkg::BYTE_W-1:0]   rdata
);

  logic [gbts_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/gbts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_ctrl
// Request checks, gap pointers, gap move sequencer and response register.
// ----------------------------------------------------------------------------
module gbts_ctrl #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  gbts_req_if.sink                              req,
  gbts_rsp_if.source                            rsp,
  output logic                                  mem_we,
  output logic [$clog2(CAPACITY)-1:0]           mem_waddr,
  output logic [gbts_pkg::BYTE_W-1:0]           mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]           mem_raddr,
  input  wire logic [gbts_pkg::BYTE_W-1:0]      mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = (PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_EDIT = 4'b1000
  } state_t;

  state_t                       state;
  logic [PW-1:0]                gap_first;
  logic [PW-1:0]                gap_past_end;
  logic [PW-1:0]                text_len;
  gbts_pkg::req_type_t          op;
  logic [PW-1:0]                target;
  logic [PW-1:0]                del_count;
  logic [gbts_pkg::BYTE_W-1:0]  ch;
  logic                         wr_pend;
  logic [AW-1:0]                wr_addr;

  logic                          rsp_valid;
  logic                          rsp_load;
  logic [gbts_pkg::BYTE_W-1:0]   rsp_byte;
  logic [PW-1:0]                 rsp_len;
  gbts_pkg::status_t             rsp_status;

  logic                accept;
  gbts_pkg::req_type_t in_op;
  logic [CW-1:0]       pos_x;
  logic [CW-1:0]       endp_x;
  logic [CW-1:0]       len_x;
  logic [PW-1:0]       pos_p;
  logic [PW-1:0]       hole_len;
  logic [PW-1:0]       phys;
  logic                chk_bad;
  logic                chk_full;
  logic                chk_noop;
  logic                move_left;

  assign req.ready       = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept          = req.valid && req.ready;
  assign in_op           = gbts_pkg::req_type_t'(req.req_type);
  assign rsp.valid       = rsp_valid;
  assign rsp.read_byte   = rsp_byte;
  assign rsp.text_length = gbts_pkg::POS_W'(rsp_len);
  assign rsp.status      = rsp_status;

  // Load the response register on an immediate answer, a read or an edit
  assign rsp_load = (accept && (chk_bad || chk_full || chk_noop)) ||
                    (state == ST_READ) || (state == ST_EDIT);

  // Request checks against the current length
  always_comb begin
    pos_x    = CW'(req.position);
    endp_x   = CW'(req.end_position);
    len_x    = CW'(text_len);
    pos_p    = PW'(req.position);
    hole_len = gap_past_end - gap_first;
    phys     = (pos_p < gap_first) ? pos_p : pos_p + hole_len;
    chk_bad  = 1'b0;
    chk_full = 1'b0;
    chk_noop = 1'b0;
    unique case (in_op)
      gbts_pkg::REQ_INSERT: begin
        chk_bad  = pos_x > len_x;
        chk_full = text_len == CAP_P;
      end
      gbts_pkg::REQ_DELETE: chk_bad = pos_x >= len_x;
      gbts_pkg::REQ_RANGE: begin
        chk_bad  = (pos_x > endp_x) || (endp_x > len_x);
        chk_noop = pos_x == endp_x;
      end
      gbts_pkg::REQ_READ: chk_bad = pos_x >= len_x;
      default: chk_bad = 1'b1;
    endcase
  end

  assign move_left = target < gap_first;

  // Memory ports: pending shift write takes priority, else the insert write
  always_comb begin
    mem_we    = wr_pend || ((state == ST_EDIT) && (op == gbts_pkg::REQ_INSERT));
    mem_waddr = wr_pend ? wr_addr : AW'(gap_first);
    mem_wdata = wr_pend ? mem_rdata : ch;
    if (state == ST_IDLE) begin
      mem_raddr = AW'(phys);
    end else if (move_left) begin
      mem_raddr = AW'(gap_first - 1'b1);
    end else begin
      mem_raddr = AW'(gap_past_end);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      gap_first    <= '0;
      gap_past_end <= CAP_P;
      text_len     <= '0;
      wr_pend      <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && !rsp.ready);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op        <= in_op;
            target    <= pos_p;
            del_count <= (in_op == gbts_pkg::REQ_DELETE) ? PW'(1)
                                                          : PW'(endp_x - pos_x);
            ch        <= req.char_value;
            if (chk_bad || chk_full || chk_noop) begin
              rsp_byte   <= '0;
              rsp_len    <= text_len;
              rsp_status <= chk_bad  ? gbts_pkg::STS_BAD :
                            chk_full ? gbts_pkg::STS_FULL : gbts_pkg::STS_DONE;
            end else if (in_op == gbts_pkg::REQ_READ) begin
              state <= ST_READ;
            end else begin
              state <= ST_MOVE;
            end
          end
        end
        ST_READ: begin
          rsp_byte   <= mem_rdata;
          rsp_len    <= text_len;
          rsp_status <= gbts_pkg::STS_DONE;
          state      <= ST_IDLE;
        end
        ST_MOVE: begin
          // Read one byte per cycle; write it across the gap in the next cycle
          if (target != gap_first) begin
            wr_pend <= 1'b1;
            if (move_left) begin
              wr_addr      <= AW'(gap_past_end - 1'b1);
              gap_first    <= gap_first - 1'b1;
              gap_past_end <= gap_past_end - 1'b1;
            end else begin
              wr_addr      <= AW'(gap_first);
              gap_first    <= gap_first + 1'b1;
              gap_past_end <= gap_past_end + 1'b1;
            end
          end else begin
            wr_pend <= 1'b0;
            state   <= ST_EDIT;
          end
        end
        ST_EDIT: begin
          rsp_byte   <= '0;
          rsp_status <= gbts_pkg::STS_DONE;
          state      <= ST_IDLE;
          if (op == gbts_pkg::REQ_INSERT) begin
            gap_first <= gap_first + 1'b1;
            text_len  <= text_len + 1'b1;
            rsp_len   <= text_len + 1'b1;
          end else begin
            gap_past_end <= gap_past_end + del_count;
            text_len     <= text_len - del_count;
            rsp_len      <= text_len - del_count;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gap_buffer_text_store_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gap_buffer_text_store_unit
// Byte text store of CAPACITY entries kept as a gap buffer in one RAM.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   req_type, position, end_position, char_value
//  rsp      out  read_byte, text_length, status
//
//  Rejected and empty requests answer in the cycle after acceptance; a read
//  passes through ST_READ (one RAM read). An edit first moves the gap by
//  its distance n in ST_MOVE, then edits in ST_EDIT: the RAM's single read
//  and write port shift one byte per cycle through the gap.
//  Synchronous reset empties the text; store contents are not cleared.
//  One request is in flight at a time; a new one is taken once the response
//  register is empty or being drained.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_unit #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gbts_req_if.sink   req,
  gbts_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [gbts_pkg::BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [gbts_pkg::BYTE_W-1:0] mem_rdata;

  gbts_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  gbts_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
